@@ hw/rtl/rce_pkg.sv @@
package rce_pkg;

    localparam int FREQ_BITS  = 16;
    localparam int FIELD_W    = 16;
    localparam int FREQ_W     = (FREQ_BITS < FIELD_W) ? FREQ_BITS : FIELD_W;
    localparam int BOUND_W    = 32;
    localparam int PROD_W     = 2 * BOUND_W;
    localparam int MUL_W      = BOUND_W + FREQ_W + 1;
    localparam int RADIX_BITS = 4;
    localparam int DIV_STEPS  = PROD_W / RADIX_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [BOUND_W-1:0] TOP_BYTE_MASK = 32'hFF00_0000;
    localparam logic [BOUND_W-1:0] ALL_ONES32    = 32'hFFFF_FFFF;
    localparam logic [7:0]         LOW_BYTE_MASK = 8'hFF;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef logic [FREQ_W-1:0] t_freq;
    typedef logic [FREQ_W:0]   t_freq_sum;

    typedef struct packed {
        logic busy;
        logic done;
    } t_md_stat;

endpackage

@@ hw/rtl/rce_muldiv.sv @@
module rce_muldiv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rce_pkg::PROD_W-1:0]    i_width,
    input  rce_pkg::t_freq_sum            i_factor,
    input  rce_pkg::t_freq                i_divisor,
    output logic [rce_pkg::BOUND_W-1:0]   o_quot,
    output rce_pkg::t_md_stat             o_stat
);
    import rce_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE   = 4'b0001,
        M_MUL_LO = 4'b0010,
        M_MUL_HI = 4'b0100,
        M_DIV    = 4'b1000
    } t_mstate;

    t_mstate               r_state, n_state;
    logic [PROD_W-1:0]     r_width;
    t_freq_sum             r_factor;
    t_freq                 r_div;
    logic [PROD_W-1:0]     r_prod, n_prod;
    t_freq                 r_rem, n_rem;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_done;
    logic [BOUND_W-1:0]    mul_a;
    logic [MUL_W-1:0]      mul_p;

    // One 32 x 17 multiplier serves both halves of the 64-bit width.
    assign mul_a = (r_state == M_MUL_HI) ? r_width[PROD_W-1:BOUND_W] : r_width[BOUND_W-1:0];
    assign mul_p = MUL_W'(mul_a) * MUL_W'(r_factor);

    // Four restoring division steps per cycle; the dividend shifts out at the
    // top of r_prod while quotient bits shift in at the bottom.
    always_comb begin
        logic [FREQ_W:0]   trial;
        logic [PROD_W-1:0] sh;
        t_freq             rem;
        sh  = r_prod;
        rem = r_rem;
        for (int k = 0; k < RADIX_BITS; k++) begin
            trial = {rem, sh[PROD_W-1]};
            sh    = {sh[PROD_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                trial = trial - {1'b0, r_div};
                sh[0] = 1'b1;
            end
            rem = trial[FREQ_W-1:0];
        end
        n_prod = sh;
        n_rem  = rem;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            M_IDLE:   if (i_start) n_state = M_MUL_LO;
            M_MUL_LO: n_state = M_MUL_HI;
            M_MUL_HI: n_state = M_DIV;
            M_DIV:    if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) n_state = M_IDLE;
            default:  n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == M_DIV) && (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
            if (r_state == M_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == M_IDLE && i_start) begin
            r_width  <= i_width;
            r_factor <= i_factor;
            r_div    <= i_divisor;
        end
        case (r_state)
            M_MUL_LO: r_prod <= PROD_W'(mul_p);
            M_MUL_HI: begin
                r_prod <= r_prod + {mul_p[BOUND_W-1:0], {BOUND_W{1'b0}}};
                r_rem  <= '0;
            end
            M_DIV: begin
                r_prod <= n_prod;
                r_rem  <= n_rem;
            end
            default: ;
        endcase
    end

    assign o_quot      = r_prod[BOUND_W-1:0];
    assign o_stat.done = r_done;
    assign o_stat.busy = (r_state != M_IDLE);

endmodule

@@ hw/rtl/range_coder_encoder_top.sv @@
// Range encoder with 32-bit low and high bounds.
// Input channel (s_axis): tuser carries the operation (encode or flush), tdata
// carries cum_freq, freq and total_freq. Output channel (m_axis): tdata is one
// byte of the compressed stream, tlast marks the final byte caused by one input
// transaction.
// An encode transaction narrows the interval with two multiply-and-divide
// passes through one shared unit. Each pass runs a start, the low and high
// multiplier products, the division at four quotient bits per cycle and a
// handoff; the encode then emits its bytes, if any. A flush emits its
// four bytes. An encode with zero freq, zero total_freq or cum_freq + freq above
// total_freq produces no bytes and leaves the state alone; the block is ready
// again next cycle. The input is ready only while no transaction is in progress.
// Bytes go through a one-entry output register, so a stalled receiver holds the
// block in its byte phase, while the last byte of a transaction may wait there
// as the next input transaction is accepted.
// Reset sets low to zero and high to all ones and empties the output register.
module range_coder_encoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // cum_freq[15:0], freq[31:16], total_freq[47:32]
    input  logic        i_s_axis_tuser,  // op[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // out_byte[7:0]
    output logic        o_m_axis_tlast
);
    import rce_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MD_LO = 4'b0010,
        S_MD_HI = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [BOUND_W-1:0]  r_low, r_high, r_qlo;
    logic [PROD_W-1:0]   r_width;
    t_freq_sum           r_cum, r_cumfr;
    t_freq               r_tot;
    logic                r_flush;
    logic [1:0]          r_cnt;
    logic                r_md_start;
    logic                r_ovalid, r_olast;
    logic [7:0]          r_obyte;

    logic                in_acc, op_valid;
    t_freq               in_cum, in_fr, in_tot;
    t_freq_sum           in_sum;
    logic [BOUND_W-1:0]  md_q;
    t_md_stat            md_stat;
    logic                top_eq, next_eq, slot_free, emit_go, emit_last;
    t_freq_sum           md_factor;

    assign in_cum   = i_s_axis_tdata[FREQ_W-1:0];
    assign in_fr    = i_s_axis_tdata[FIELD_W +: FREQ_W];
    assign in_tot   = i_s_axis_tdata[2*FIELD_W +: FREQ_W];
    assign in_sum   = {1'b0, in_cum} + {1'b0, in_fr};
    assign op_valid = (in_fr != '0) && (in_tot != '0) && (in_sum <= {1'b0, in_tot});

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    assign md_factor = (r_state == S_MD_HI) ? r_cumfr : r_cum;

    rce_muldiv u_muldiv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_md_start),
        .i_width   (r_width),
        .i_factor  (md_factor),
        .i_divisor (r_tot),
        .o_quot    (md_q),
        .o_stat    (md_stat)
    );

    assign top_eq    = (r_low & TOP_BYTE_MASK) == (r_high & TOP_BYTE_MASK);
    assign next_eq   = r_low[23:16] == r_high[23:16];
    assign slot_free = !r_ovalid || i_m_axis_tready;
    assign emit_go   = (r_state == S_EMIT) && (r_flush || top_eq) && slot_free;
    // An encode byte is final when the next pair of bytes will differ; any fourth byte is final.
    assign emit_last = (r_cnt == 2'd3) || (!r_flush && !next_eq);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_s_axis_tuser == OP_FLUSH) begin
                    n_state = S_EMIT;
                end else if (in_acc && op_valid) begin
                    n_state = S_MD_LO;
                end
            end
            S_MD_LO: if (md_stat.done) n_state = S_MD_HI;
            S_MD_HI: if (md_stat.done) n_state = S_EMIT;
            S_EMIT: begin
                if (!r_flush && !top_eq) begin
                    n_state = S_IDLE;
                end else if (emit_go && emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_low      <= '0;
            r_high     <= ALL_ONES32;
            r_md_start <= 1'b0;
            r_ovalid   <= 1'b0;
            r_cnt      <= '0;
            r_flush    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_md_start <= (in_acc && i_s_axis_tuser == OP_ENCODE && op_valid) ||
                          (r_state == S_MD_LO && md_stat.done);
            if (in_acc) begin
                r_flush <= (i_s_axis_tuser == OP_FLUSH);
                r_cnt   <= '0;
            end
            if (r_state == S_MD_HI && md_stat.done) begin
                r_low  <= r_low + r_qlo;
                r_high <= r_low + md_q - 32'd1;
            end
            if (emit_go) begin
                r_cnt    <= r_cnt + 2'd1;
                r_low    <= {r_low[23:0], 8'h00};
                // A flush only drains low; high keeps its value.
                if (!r_flush) begin
                    r_high <= {r_high[23:0], LOW_BYTE_MASK};
                end
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cum   <= {1'b0, in_cum};
            r_cumfr <= in_sum;
            r_tot   <= in_tot;
            r_width <= {{BOUND_W{1'b0}}, r_high} - {{BOUND_W{1'b0}}, r_low} + PROD_W'(1);
        end
        if (r_state == S_MD_LO && md_stat.done) begin
            r_qlo <= md_q;
        end
        if (emit_go) begin
            r_obyte <= r_flush ? r_low[31:24] : r_high[31:24];
            r_olast <= emit_last;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_obyte;
    assign o_m_axis_tlast  = r_olast;

endmodule

@@ hw/rtl/rce_checker.sv @@
module rce_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata,
    input logic        o_m_axis_tlast
);
    import rce_pkg::*;

    // A stalled output byte keeps its valid.
    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output valid dropped while stalled");

    // A stalled output byte keeps its payload.
    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output payload changed while stalled");

    // A flush always occupies the block for its byte phase.
    a_flush_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == OP_FLUSH |=> !o_s_axis_tready)
        else $error("input ready right after a flush transaction");

    // Reset empties the output register and leaves the input ready.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("wrong handshake state after reset");

endmodule

bind range_coder_encoder_top rce_checker u_rce_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

@@ tb/rce_byte_scoreboard.sv @@
// Watches both stream channels of the range encoder and keeps a cycle-free
// model of the coder interval. Every accepted input transaction is turned
// into the bytes it must produce. Every accepted output byte is checked
// against the oldest of those bytes.
module rce_byte_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // cum_freq[15:0], freq[31:16], total_freq[47:32]
    input  logic        i_s_axis_tuser,  // op[0]
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [7:0]  i_m_axis_tdata,  // out_byte[7:0]
    input  logic        i_m_axis_tlast,
    output int          o_fail_cnt,
    output int          o_expect_cnt,
    output int          o_byte_cnt,
    output int          o_inverted_cnt
);
    import rce_pkg::*;

    localparam logic [15:0] FREQ_MASK = 16'((64'd1 << FREQ_W) - 64'd1);

    typedef struct packed {
        logic [7:0] code_byte;
        logic       tail;
    } t_coded_byte;

    t_coded_byte         byte_fifo[$];
    logic [BOUND_W-1:0]  coder_lo = '0;
    logic [BOUND_W-1:0]  coder_hi = ALL_ONES32;

    // Advances the interval by one input transaction and queues its bytes.
    task automatic step_coder(input logic op, input logic [15:0] cum_in,
                              input logic [15:0] fr_in, input logic [15:0] tot_in);
        logic [15:0] cum;
        logic [15:0] fr;
        logic [15:0] tot;
        logic [16:0] upper;
        logic [63:0] span;
        logic [63:0] lo_next;
        logic [63:0] hi_next;
        logic [7:0]  emitted[4];
        int          n;
        t_coded_byte entry;
        cum = cum_in & FREQ_MASK;
        fr  = fr_in & FREQ_MASK;
        tot = tot_in & FREQ_MASK;
        n   = 0;
        if (op == OP_FLUSH) begin
            for (int k = 0; k < 4; k++) begin
                emitted[k] = coder_lo[31:24];
                coder_lo   = coder_lo << 8;
            end
            n = 4;
        end else begin
            upper = {1'b0, cum} + {1'b0, fr};
            if (fr == '0 || tot == '0 || upper > {1'b0, tot})
                return;
            if (coder_hi < coder_lo)
                o_inverted_cnt <= o_inverted_cnt + 1;
            // Width and products wrap at 64 bits when the interval is inverted.
            span    = {32'd0, coder_hi} - {32'd0, coder_lo} + 64'd1;
            lo_next = {32'd0, coder_lo} + (span * {48'd0, cum}) / {48'd0, tot};
            hi_next = {32'd0, coder_lo} + (span * {47'd0, upper}) / {48'd0, tot} - 64'd1;
            coder_lo = lo_next[31:0];
            coder_hi = hi_next[31:0];
            while (n < 4 && (coder_lo & TOP_BYTE_MASK) == (coder_hi & TOP_BYTE_MASK)) begin
                emitted[n] = coder_hi[31:24];
                n++;
                coder_lo = coder_lo << 8;
                coder_hi = (coder_hi << 8) | {24'd0, LOW_BYTE_MASK};
            end
        end
        for (int k = 0; k < n; k++) begin
            entry.code_byte = emitted[k];
            entry.tail      = (k == n - 1);
            byte_fifo.insert(byte_fifo.size(), entry);
        end
    endtask

    always @(posedge i_clk) begin
        t_coded_byte want;
        if (!i_rst_n) begin
            byte_fifo.delete();
            coder_lo = '0;
            coder_hi = ALL_ONES32;
        end else begin
            // An output byte always belongs to an earlier input transaction,
            // so the byte is retired before a new input is modeled.
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                o_byte_cnt <= o_byte_cnt + 1;
                if (byte_fifo.size() == 0) begin
                    $display("%0t: unexpected byte %02h last %0b, expected nothing",
                             $time, i_m_axis_tdata, i_m_axis_tlast);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    want = byte_fifo.pop_front();
                    if (want.code_byte !== i_m_axis_tdata || want.tail !== i_m_axis_tlast) begin
                        $display("%0t: byte mismatch, expected %02h last %0b, got %02h last %0b",
                                 $time, want.code_byte, want.tail, i_m_axis_tdata,
                                 i_m_axis_tlast);
                        o_fail_cnt <= o_fail_cnt + 1;
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                step_coder(i_s_axis_tuser, i_s_axis_tdata[15:0], i_s_axis_tdata[31:16],
                           i_s_axis_tdata[47:32]);
        end
        o_expect_cnt <= byte_fifo.size();
    end

endmodule

@@ tb/range_coder_encoder_top_tb.sv @@
module range_coder_encoder_top_tb;
    import rce_pkg::*;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [47:0] i_s_axis_tdata  = '0;
    logic        i_s_axis_tuser  = OP_ENCODE;
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [7:0]  o_m_axis_tdata;
    logic        o_m_axis_tlast;

    int   fail_cnt;
    int   expect_cnt;
    int   byte_cnt;
    int   inverted_cnt;
    logic flat_out = 1'b0;
    int   n_encode  = 0;
    int   n_ignored = 0;
    int   n_flush   = 0;

    range_coder_encoder_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    rce_byte_scoreboard u_scoreboard (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tlast  (o_m_axis_tlast),
        .o_fail_cnt      (fail_cnt),
        .o_expect_cnt    (expect_cnt),
        .o_byte_cnt      (byte_cnt),
        .o_inverted_cnt  (inverted_cnt)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    // Receiver side: alternating runs of ready and stall.
    initial begin
        int hold_cnt;
        int stall;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (hold_cnt > 0) begin
                hold_cnt--;
            end else if (flat_out) begin
                i_m_axis_tready <= 1'b1;
            end else if (i_m_axis_tready) begin
                stall = pick_gap();
                if (stall > 0) begin
                    i_m_axis_tready <= 1'b0;
                    hold_cnt = stall - 1;
                end
            end else begin
                i_m_axis_tready <= 1'b1;
                hold_cnt = 2 * pick_gap();
            end
        end
    end

    task automatic send_item(input logic op, input logic [15:0] cum, input logic [15:0] fr,
                             input logic [15:0] tot);
        int gap;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {tot, fr, cum};
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (op == OP_FLUSH)
            n_flush++;
        else if (fr == 0 || tot == 0 || {1'b0, cum} + {1'b0, fr} > {1'b0, tot})
            n_ignored++;
        else
            n_encode++;
        gap = flat_out ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= {16'($urandom()), $urandom()};
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Holds the input off until every predicted byte has been delivered.
    task automatic drain_bytes();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expect_cnt != 0) @(posedge i_clk);
    endtask

    task automatic send_symbol(input int style);
        int tot;
        int fr;
        int cum;
        case (style)
            0:       tot = $urandom_range(1, 16);
            1:       tot = 65535;
            default: tot = $urandom_range(1, 65535);
        endcase
        fr  = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(1, tot);
        cum = $urandom_range(0, tot - fr);
        send_item(OP_ENCODE, 16'(cum), 16'(fr), 16'(tot));
    endtask

    task automatic send_bad_symbol();
        int tot;
        int fr;
        int cum;
        case ($urandom_range(0, 2))
            0: send_item(OP_ENCODE, 16'($urandom()), 16'd0, 16'($urandom()));
            1: send_item(OP_ENCODE, 16'($urandom()), 16'($urandom()), 16'd0);
            default: begin
                tot = $urandom_range(1, 65534);
                fr  = $urandom_range(1, 65535);
                cum = $urandom_range((tot >= fr) ? tot - fr + 1 : 0, 65535);
                send_item(OP_ENCODE, 16'(cum), 16'(fr), 16'(tot));
            end
        endcase
    endtask

    initial begin
        int n_sym;
        int valid_sent;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Ignored symbols, including a sum that would wrap in 16 bits.
        send_item(OP_ENCODE, 16'd0, 16'd0, 16'd100);
        send_item(OP_ENCODE, 16'd0, 16'd5, 16'd0);
        send_item(OP_ENCODE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(OP_ENCODE, 16'd1, 16'hFFFF, 16'hFFFF);
        // Full range, the narrowest symbol and the smallest model.
        send_item(OP_ENCODE, 16'd0, 16'hFFFF, 16'hFFFF);
        send_item(OP_ENCODE, 16'hFFFE, 16'd1, 16'hFFFF);
        send_item(OP_ENCODE, 16'd0, 16'd1, 16'd1);
        send_item(OP_FLUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // Walk the interval onto a byte boundary until it collapses and
        // inverts, then keep coding with high below low.
        send_item(OP_ENCODE, 16'd255, 16'd1, 16'hFFFF);
        send_item(OP_ENCODE, 16'd65279, 16'd2, 16'hFFFF);
        send_item(OP_ENCODE, 16'd0, 16'd1, 16'd3);
        send_item(OP_ENCODE, 16'd1000, 16'd3000, 16'hFFFF);
        send_item(OP_ENCODE, 16'hAAAA, 16'h5555, 16'hFFFF);
        send_item(OP_FLUSH, 16'd0, 16'd0, 16'd0);
        send_item(OP_FLUSH, 16'h5555, 16'hAAAA, 16'h1234);
        send_item(OP_ENCODE, 16'h5555, 16'hAAAA, 16'hFFFF);
        send_item(OP_ENCODE, 16'd0, 16'd1, 16'hFFFF);
        send_item(OP_ENCODE, 16'd0, 16'd1, 16'hFFFF);
        send_item(OP_ENCODE, 16'h7FFF, 16'h8000, 16'hFFFF);
        send_item(OP_FLUSH, 16'd0, 16'd0, 16'd0);
        drain_bytes();

        valid_sent = 0;
        while (valid_sent < 400) begin
            flat_out <= ((valid_sent % 150) >= 90 && (valid_sent % 150) < 120);
            if ($urandom_range(0, 99) < 80) begin
                // A message: a run of symbols, usually closed by a flush.
                n_sym = $urandom_range(1, 12);
                for (int k = 0; k < n_sym; k++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_bad_symbol();
                    send_symbol($urandom_range(0, 5));
                    valid_sent++;
                end
                if ($urandom_range(0, 99) < 85) begin
                    send_item(OP_FLUSH, 16'($urandom()), 16'($urandom()), 16'($urandom()));
                    valid_sent++;
                end
            end else if ($urandom_range(0, 1) == 0) begin
                send_item(OP_FLUSH, 16'($urandom()), 16'($urandom()), 16'($urandom()));
                valid_sent++;
            end else begin
                send_bad_symbol();
            end
            if ($urandom_range(0, 19) == 0)
                drain_bytes();
        end

        drain_bytes();
        repeat (100) @(posedge i_clk);
        $display("Sent %0d symbols, %0d ignored symbols and %0d flushes.",
                 n_encode, n_ignored, n_flush);
        $display("Checked %0d output bytes; %0d symbols were coded on an inverted interval.",
                 byte_cnt, inverted_cnt);
        if (fail_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #4000000;
        $display("Timed out with %0d bytes still outstanding.", expect_cnt);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
